[rtl/dxtbd_pkg.sv]
// Shared types, format codes and constant-divide helpers for the DXT block decoder.
package dxtbd_pkg;

    // Block format codes; the unused code 3 decodes like DXT5 (bit 1 selects interpolated alpha).
    localparam logic [1:0] FMT_DXT1 = 2'd0;
    localparam logic [1:0] FMT_DXT3 = 2'd1;
    localparam logic [1:0] FMT_DXT5 = 2'd2;

    localparam int unsigned NUM_ROWS = 4;
    localparam int unsigned NUM_COLS = 4;

    // Decoded palettes for one block. Colors are packed {blue, green, red}.
    typedef struct packed {
        logic [3:0][23:0] color;
        logic [7:0]       color3_alpha;
        logic [7:0][7:0]  alpha;
    } pal_t;

    // Floor of x / 3 for x below 768: multiply by the scaled reciprocal.
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] prod;
        begin
            prod = 20'(x) * 20'd683;
            div3 = prod[18:11];
        end
    endfunction

    // Floor of x / 7 for x below 1792.
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [22:0] prod;
        begin
            prod = 23'(x) * 23'd2341;
            div7 = prod[21:14];
        end
    endfunction

    // Floor of x / 5 for x below 1280.
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [22:0] prod;
        begin
            prod = 23'(x) * 23'd3277;
            div5 = prod[21:14];
        end
    endfunction

endpackage

[rtl/dxtbd_palette.sv]
// Builds the color and alpha palettes of one compressed block.
module dxtbd_palette
    import dxtbd_pkg::*;
(
    input  logic [15:0] c0,
    input  logic [15:0] c1,
    input  logic [7:0]  a0,
    input  logic [7:0]  a1,
    input  logic [1:0]  fmt,
    output pal_t        pal
);

    logic [2:0][7:0] e0;
    logic [2:0][7:0] e1;
    logic [2:0][7:0] third0;
    logic [2:0][7:0] third1;
    logic [2:0][7:0] half;
    logic            four_color;
    logic            punch;

    // RGB565 expansion by plain left shift.
    assign e0[0] = {c0[15:11], 3'b000};
    assign e0[1] = {c0[10:5], 2'b00};
    assign e0[2] = {c0[4:0], 3'b000};
    assign e1[0] = {c1[15:11], 3'b000};
    assign e1[1] = {c1[10:5], 2'b00};
    assign e1[2] = {c1[4:0], 3'b000};

    assign four_color = (c0 > c1);
    assign punch      = !four_color && (fmt == FMT_DXT1);

    // Per-channel interpolants.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            third0[k] = div3(10'({e0[k], 1'b0}) + 10'(e1[k]));
            third1[k] = div3(10'({e1[k], 1'b0}) + 10'(e0[k]));
            half[k]   = 8'((9'(e0[k]) + 9'(e1[k])) >> 1);
        end
    end

    // Color palette; the fourth entry is transparent black in punch-through mode.
    always_comb
    begin
        pal.color[0] = {e0[2], e0[1], e0[0]};
        pal.color[1] = {e1[2], e1[1], e1[0]};
        if (four_color)
        begin
            pal.color[2] = {third0[2], third0[1], third0[0]};
            pal.color[3] = {third1[2], third1[1], third1[0]};
        end
        else
        begin
            pal.color[2] = {half[2], half[1], half[0]};
            pal.color[3] = punch ? 24'd0 : {half[2], half[1], half[0]};
        end
        pal.color3_alpha = punch ? 8'd0 : 8'hFF;
    end

    // Eight-entry interpolated alpha palette.
    always_comb
    begin
        logic [10:0] sum7;
        logic [10:0] sum5;
        pal.alpha[0] = a0;
        pal.alpha[1] = a1;
        for (int i = 2; i < 8; i++)
        begin
            sum7 = 11'(a0) * 11'(8 - i) + 11'(a1) * 11'(i - 1);
            sum5 = 11'(a0) * 11'((6 - i) & 7) + 11'(a1) * 11'(i - 1);
            if (a0 > a1)
            begin
                pal.alpha[i] = div7(sum7);
            end
            else if (i == 6)
            begin
                pal.alpha[i] = 8'd0;
            end
            else if (i == 7)
            begin
                pal.alpha[i] = 8'hFF;
            end
            else
            begin
                pal.alpha[i] = div5(sum5);
            end
        end
    end

endmodule

[rtl/dxtbd_texel_lane.sv]
// Decodes one texel from the block palettes and its indices.
module dxtbd_texel_lane
    import dxtbd_pkg::*;
(
    input  pal_t        pal,
    input  logic [1:0]  fmt,
    input  logic [1:0]  color_idx,
    input  logic [3:0]  alpha_nib,
    input  logic [2:0]  alpha_idx,
    output logic [31:0] texel
);

    logic [7:0] alpha;

    // Alpha source depends on the block format.
    always_comb
    begin
        priority if (fmt == FMT_DXT1)
        begin
            alpha = (color_idx == 2'd3) ? pal.color3_alpha : 8'hFF;
        end
        else if (fmt == FMT_DXT3)
        begin
            // Four-bit alpha times 17 is the nibble repeated.
            alpha = {alpha_nib, alpha_nib};
        end
        else
        begin
            alpha = pal.alpha[alpha_idx];
        end
    end

    assign texel = {alpha, pal.color[color_idx]};

endmodule

[rtl/dxt_block_decoder_core.sv]
// S3TC DXT1/DXT3/DXT5 block decoder: one 4x4 block in, four texel rows out.
// Each block is registered with its palettes, then each row in the output row register.
// Rows leave the single output row register one per cycle while row_stall is low.
// A new block is accepted in the cycle the held block's last row enters the output register.
// Reset (rst_n low, asynchronous) empties the pipeline and sets the block format to DXT1.
module dxt_block_decoder_core
    import dxtbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  block_format,
    input  logic        block_valid,
    output logic        block_stall,
    input  logic [63:0] color_block,
    input  logic [63:0] alpha_block,
    output logic        row_valid,
    input  logic        row_stall,
    output logic [1:0]  row_index,
    output logic [31:0] texel_col0,
    output logic [31:0] texel_col1,
    output logic [31:0] texel_col2,
    output logic [31:0] texel_col3,
    output logic        last_row
);

    logic [1:0]  fmt_reg;
    pal_t        pal_new;
    pal_t        pal_reg;
    logic [31:0] cidx_reg;
    logic [63:0] ablk_reg;
    logic        held_reg;
    logic        held_next;
    logic [1:0]  row_reg;
    logic [1:0]  row_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  out_row_reg;
    logic        out_last_reg;
    logic [NUM_COLS-1:0][31:0] out_texel_reg;
    logic [NUM_COLS-1:0][31:0] lane_texel;
    logic        out_advance;
    logic        emit;
    logic        accept;

    // Configuration transactions are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_DXT1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            fmt_reg <= block_format;
        end
    end

    // Handshake control: a held block emits a row whenever the output register can take one.
    assign out_advance = !out_valid_reg || !row_stall;
    assign emit        = held_reg && out_advance;
    assign block_stall = held_reg && !(emit && (row_reg == 2'(NUM_ROWS - 1)));
    assign accept      = block_valid && !block_stall;

    always_comb
    begin
        held_next      = held_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            row_next = row_reg + 2'd1;
            if (row_reg == 2'(NUM_ROWS - 1))
            begin
                held_next = 1'b0;
            end
        end
        if (accept)
        begin
            held_next = 1'b1;
            row_next  = 2'd0;
        end
        if (out_advance)
        begin
            out_valid_next = held_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= 1'b0;
            row_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg      <= held_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Palette stage: built from the incoming block and held for its four rows.
    dxtbd_palette u_palette (
        .c0  (color_block[15:0]),
        .c1  (color_block[31:16]),
        .a0  (alpha_block[7:0]),
        .a1  (alpha_block[15:8]),
        .fmt (fmt_reg),
        .pal (pal_new)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pal_reg  <= pal_new;
            cidx_reg <= color_block[63:32];
            ablk_reg <= alpha_block;
        end
    end

    // Four texel lanes decode the current row side by side.
    for (genvar k = 0; k < NUM_COLS; k++)
    begin : g_lane
        logic [3:0] texel_num;
        assign texel_num = {row_reg, 2'(k)};

        dxtbd_texel_lane u_lane (
            .pal       (pal_reg),
            .fmt       (fmt_reg),
            .color_idx (cidx_reg[{texel_num, 1'b0} +: 2]),
            .alpha_nib (ablk_reg[{texel_num, 2'b00} +: 4]),
            .alpha_idx (ablk_reg[6'd16 + 6'(texel_num) * 6'd3 +: 3]),
            .texel     (lane_texel[k])
        );
    end

    // Merge the lane results into the output row register.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_row_reg   <= row_reg;
            out_last_reg  <= (row_reg == 2'(NUM_ROWS - 1));
            out_texel_reg <= lane_texel;
        end
    end

    assign row_valid  = out_valid_reg;
    assign row_index  = out_row_reg;
    assign last_row   = out_last_reg;
    assign texel_col0 = out_texel_reg[0];
    assign texel_col1 = out_texel_reg[1];
    assign texel_col2 = out_texel_reg[2];
    assign texel_col3 = out_texel_reg[3];

endmodule

[dv/tb_dxt_block_decoder_core.sv]
// Self-checking testbench for the DXT1/DXT3/DXT5 block decoder core.
`timescale 1ns / 100ps

module tb_dxt_block_decoder_core;
    import dxtbd_pkg::*;

    // Format code 3 has no name in the package; it decodes with interpolated alpha.
    localparam logic [1:0] FMT_SPARE = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned RANDOM_PHASES = 5;
    localparam int unsigned BLOCKS_PER_PHASE = 40;

    // One decoded texel row as it leaves the block.
    typedef struct packed {
        logic [1:0]       row;
        logic [3:0][31:0] texel;
        logic             last;
    } texel_row_t;

    // Decodes each accepted block into its four rows and checks the rows as they leave.
    class dxt_row_checker;
        logic [1:0]  active_fmt = FMT_DXT1;
        texel_row_t  expected_rows[$];
        int unsigned mismatches = 0;
        int unsigned blocks_noted = 0;
        int unsigned rows_checked = 0;

        function void note_block(logic [63:0] cb, logic [63:0] ab);
            int unsigned ep0[3];
            int unsigned ep1[3];
            int unsigned pal[4][3];
            int unsigned apal[8];
            int unsigned av0;
            int unsigned av1;
            int unsigned ci;
            int unsigned t;
            int unsigned alpha;
            logic [15:0] c0;
            logic [15:0] c1;
            logic        four_color;
            texel_row_t  exp_row;
            c0 = cb[15:0];
            c1 = cb[31:16];
            four_color = (c0 > c1);

            // Expand RGB565 endpoints by a plain shift, no bit replication.
            ep0[0] = {c0[15:11], 3'b000};
            ep0[1] = {c0[10:5], 2'b00};
            ep0[2] = {c0[4:0], 3'b000};
            ep1[0] = {c1[15:11], 3'b000};
            ep1[1] = {c1[10:5], 2'b00};
            ep1[2] = {c1[4:0], 3'b000};

            // Color palette: four entries with floor thirds, or three plus black / midpoint.
            for (int k = 0; k < 3; k++)
            begin
                pal[0][k] = ep0[k];
                pal[1][k] = ep1[k];
                if (four_color)
                begin
                    pal[2][k] = (2 * ep0[k] + ep1[k]) / 3;
                    pal[3][k] = (2 * ep1[k] + ep0[k]) / 3;
                end
                else
                begin
                    pal[2][k] = (ep0[k] + ep1[k]) / 2;
                    pal[3][k] = (active_fmt == FMT_DXT1) ? 0 : pal[2][k];
                end
            end

            // Interpolated alpha palette, used by DXT5 and the spare code.
            av0 = ab[7:0];
            av1 = ab[15:8];
            apal[0] = av0;
            apal[1] = av1;
            if (av0 > av1)
            begin
                for (int unsigned i = 2; i < 8; i++)
                    apal[i] = ((8 - i) * av0 + (i - 1) * av1) / 7;
            end
            else
            begin
                for (int unsigned i = 2; i < 6; i++)
                    apal[i] = ((6 - i) * av0 + (i - 1) * av1) / 5;
                apal[6] = 0;
                apal[7] = 255;
            end

            // Build the four rows, top to bottom.
            for (int unsigned r = 0; r < 4; r++)
            begin
                exp_row.row = r[1:0];
                exp_row.last = (r == 3);
                for (int unsigned k = 0; k < 4; k++)
                begin
                    t = r * 4 + k;
                    ci = cb[32 + 2 * t +: 2];
                    if (active_fmt == FMT_DXT1)
                        alpha = (ci == 3 && !four_color) ? 0 : 255;
                    else if (active_fmt == FMT_DXT3)
                        alpha = ab[4 * t +: 4] * 17;
                    else
                        alpha = apal[ab[16 + 3 * t +: 3]];
                    exp_row.texel[k] = {alpha[7:0], pal[ci][2][7:0], pal[ci][1][7:0],
                                        pal[ci][0][7:0]};
                end
                expected_rows.push_back(exp_row);
            end
            blocks_noted++;
        endfunction

        function void check_row(texel_row_t got);
            texel_row_t exp_row;
            logic       bad;
            if (expected_rows.size() == 0)
            begin
                $error("Row %0d leaves with no block outstanding", got.row);
                mismatches++;
                return;
            end
            exp_row = expected_rows.pop_front();
            bad = 1'b0;
            rows_checked++;
            if (got.row != exp_row.row)
            begin
                $error("row_index: expected %0d, got %0d", exp_row.row, got.row);
                bad = 1'b1;
            end
            for (int k = 0; k < 4; k++)
            begin
                if (got.texel[k] != exp_row.texel[k])
                begin
                    $error("texel_col%0d: expected %08h, got %08h", k, exp_row.texel[k],
                           got.texel[k]);
                    bad = 1'b1;
                end
            end
            if (got.last != exp_row.last)
            begin
                $error("last_row: expected %0d, got %0d", exp_row.last, got.last);
                bad = 1'b1;
            end
            if (bad)
                mismatches++;
        endfunction

        function int unsigned pending();
            return expected_rows.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  block_format;
    logic        block_valid;
    logic        block_stall;
    logic [63:0] color_block;
    logic [63:0] alpha_block;
    logic        row_valid;
    logic        row_stall;
    logic [1:0]  row_index;
    logic [31:0] texel_col0;
    logic [31:0] texel_col1;
    logic [31:0] texel_col2;
    logic [31:0] texel_col3;
    logic        last_row;

    dxt_row_checker sb;
    int unsigned    cycle_count;
    int unsigned    tx_idle_pct;
    int unsigned    rx_idle_pct;
    int unsigned    stall_left;

    dxt_block_decoder_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .block_format (block_format),
        .block_valid  (block_valid),
        .block_stall  (block_stall),
        .color_block  (color_block),
        .alpha_block  (alpha_block),
        .row_valid    (row_valid),
        .row_stall    (row_stall),
        .row_index    (row_index),
        .texel_col0   (texel_col0),
        .texel_col1   (texel_col1),
        .texel_col2   (texel_col2),
        .texel_col3   (texel_col3),
        .last_row     (last_row)
    );

    // 20 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog on the total run length.
    initial
        cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver stalls come in bursts of random length.
    initial
    begin
        row_stall = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                row_stall = 1'b1;
            end
            else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct)
            begin
                stall_left = $urandom_range(1, 11) - 1;
                row_stall = 1'b1;
            end
            else
                row_stall = 1'b0;
        end
    end

    // Every row transaction is checked against the oldest expected row.
    always @(posedge clk)
    begin
        if (rst_n && row_valid && !row_stall)
            sb.check_row('{row: row_index,
                           texel: {texel_col3, texel_col2, texel_col1, texel_col0},
                           last: last_row});
    end

    // Present one block and hold it until the block transaction completes.
    task automatic send_block(input logic [63:0] cb, input logic [63:0] ab);
        @(negedge clk);
        block_valid = 1'b1;
        color_block = cb;
        alpha_block = ab;
        do
            @(posedge clk);
        while (block_stall);
        sb.note_block(cb, ab);
    endtask

    // Sender idles for the given number of cycles; the payload wanders meanwhile.
    task automatic sender_pause(input int unsigned cycles);
        @(negedge clk);
        block_valid = 1'b0;
        color_block = {$urandom, $urandom};
        alpha_block = {$urandom, $urandom};
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Let every outstanding row leave, then write a new block format.
    task automatic write_format(input logic [1:0] fmt);
        @(negedge clk);
        block_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        block_format = fmt;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.active_fmt = fmt;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Random blocks, biased toward equal endpoints now and then.
    task automatic send_random_blocks(input int unsigned count);
        logic [63:0] cb;
        logic [63:0] ab;
        for (int unsigned n = 0; n < count; n++)
        begin
            cb = {$urandom, $urandom};
            ab = {$urandom, $urandom};
            if ($urandom_range(0, 7) == 0)
                cb[31:16] = cb[15:0];
            if ($urandom_range(0, 7) == 0)
                ab[15:8] = ab[7:0];
            if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
                sender_pause($urandom_range(1, 11));
            send_block(cb, ab);
        end
    endtask

    // Main sequence.
    initial
    begin
        sb = new;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        block_format = FMT_DXT1;
        block_valid = 1'b0;
        color_block = '0;
        alpha_block = '0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // DXT1 from reset: endpoint ordering, transparent black, all-zero and all-one blocks.
        send_block(64'h0, 64'h0);
        send_block(64'hE4E4E4E4_0000FFFF, 64'h0);
        send_block(64'hE4E4E4E4_FFFF0000, 64'hFFFFFFFF_FFFFFFFF);
        send_block(64'hFFFFFFFF_12341234, 64'h0);
        send_block(64'hFFFFFFFF_FFFFFFFF, 64'h0);
        send_block(64'h1B6C93D2_07E0F800, 64'h0);

        // DXT3: every explicit alpha nibble, and the midpoint in three-color mode.
        write_format(FMT_DXT3);
        send_block(64'hE4E4E4E4_0000FFFF, 64'hFEDCBA98_76543210);
        send_block(64'hE4E4E4E4_FFFF0000, 64'h01234567_89ABCDEF);
        send_block(64'hFFFFFFFF_FFFFFFFF, 64'hFFFFFFFF_FFFFFFFF);
        send_block(64'h0, 64'h0);
        send_block(64'hFFFFFFFF_001F001F, 64'hF0F0F0F0_0F0F0F0F);

        // DXT5: both alpha palette modes with every alpha index, and the extremes.
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        write_format(FMT_DXT5);
        send_block(64'hE4E4E4E4_0000FFFF, 64'hFAC688FA_C68800FF);
        send_block(64'hE4E4E4E4_0000FFFF, 64'hFAC688FA_C688FF00);
        send_block(64'hE4E4E4E4_FFFF0000, 64'hFAC688FA_C6888080);
        send_block(64'hE4E4E4E4_FFFF0000, 64'hFAC688FA_C68801FE);
        send_block(64'hFFFFFFFF_FFFFFFFF, 64'hFFFFFFFF_FFFFFFFF);
        send_block(64'h0, 64'h0);
        send_block(64'h55AA33CC_F81F07E0, 64'h12345678_9ABC40C0);
        send_block(64'hAAAAAAAA_12345678, 64'hFAC688FA_C68810F0);

        // The spare code decodes like DXT5.
        write_format(FMT_SPARE);
        send_block(64'hE4E4E4E4_FFFF0000, 64'hFAC688FA_C68800FF);
        send_block(64'hE4E4E4E4_0000FFFF, 64'hFAC688FA_C688FF00);
        send_block(64'hFFFFFFFF_FFFFFFFF, 64'h0);

        // Random phases over every format; the last phase runs with no idling.
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: write_format(FMT_DXT1);
                1: write_format(FMT_DXT3);
                2: write_format(FMT_DXT5);
                3: write_format(FMT_SPARE);
                default: write_format(2'($urandom_range(0, 3)));
            endcase
            if (phase == RANDOM_PHASES - 1)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else if (phase == 1)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 40;
            end
            else
            begin
                tx_idle_pct = $urandom_range(10, 50);
                rx_idle_pct = $urandom_range(10, 50);
            end
            send_random_blocks(BLOCKS_PER_PHASE);
        end

        // Drain, then wait for any stray row.
        @(negedge clk);
        block_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display(
            "Decoded %0d blocks into %0d checked rows over DXT1, DXT3, DXT5 and the spare code,",
            sb.blocks_noted, sb.rows_checked);
        $display("with random sender gaps and receiver stalls; %0d rows mismatched.",
                 sb.mismatches);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
